FILE: hw/rtl/gsct_pkg.sv
// ----------------------------------------------------------------------------
// gsct_pkg: shared types and constants for the grid segment cell walker
// Field widths, register indexes and the controller/datapath command and status words.
// ----------------------------------------------------------------------------
package gsct_pkg;

    // fixed field widths
    localparam int COORD_W   = 14;   // endpoint coordinate, signed fixed point
    localparam int TAG_W     = 16;   // segment id / tag
    localparam int CELL_W    = 6;    // cell_x / cell_y on the output
    localparam int INDEX_W   = 8;    // linear cell index
    localparam int CFG_W     = 5;    // grid_columns / grid_rows
    localparam int DELTA_W   = 14;   // absolute coordinate difference
    localparam int COUNT_W   = 6;    // results issued for one segment
    localparam int MAX_RES   = 63;   // hard cap on results per segment
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture a new segment
        logic mul_x;   // first error product, cell span
        logic mul_y;   // second error product
        logic step;    // emit current cell and advance
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fin;     // current cell is the final one
    } t_dp_sts;

endpackage

FILE: hw/rtl/gsct_ctrl.sv
// ----------------------------------------------------------------------------
// gsct_ctrl: sequencer for the grid segment cell walker
// Steps each segment through setup and the walk; owns both handshakes.
// ----------------------------------------------------------------------------
module gsct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  gsct_pkg::t_dp_sts  i_sts,
    output gsct_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    // output register may be refilled when empty or being drained
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul_x = (r_state == ST_MUL_X);
        o_cmd.mul_y = (r_state == ST_MUL_Y);
        o_cmd.step  = (r_state == ST_WALK) && w_slot_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL_X;
            end
            ST_MUL_X: n_state = ST_MUL_Y;
            ST_MUL_Y: n_state = ST_WALK;
            ST_WALK: begin
                if (w_slot_free && i_sts.fin) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        n_in_stall  = (n_state != ST_IDLE);
        n_out_valid = o_cmd.step ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/gsct_dpath.sv
// ----------------------------------------------------------------------------
// gsct_dpath: datapath of the grid segment cell walker
// Grid registers, endpoint flooring, shared error multiplier, walk registers.
// ----------------------------------------------------------------------------
module gsct_dpath #(
    parameter int MAX_GRID_SIDE = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gsct_pkg::t_dp_cmd                      i_cmd,
    output gsct_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_cfg_we,
    input  logic [gsct_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gsct_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_x_start,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_y_start,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_x_end,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_y_end,
    input  logic [gsct_pkg::TAG_W-1:0]             i_segment_id,
    output logic signed [gsct_pkg::CELL_W-1:0]     o_cell_x,
    output logic signed [gsct_pkg::CELL_W-1:0]     o_cell_y,
    output logic [gsct_pkg::INDEX_W-1:0]           o_cell_index,
    output logic [gsct_pkg::TAG_W-1:0]             o_segment_tag,
    output logic                                   o_inside_res,
    output logic                                   o_last
);

    localparam int CW   = gsct_pkg::COORD_W - FRACTION_BITS;   // cell coordinate
    localparam int NW   = CW + 1;                               // steps to walk
    localparam int FW   = FRACTION_BITS + 1;                    // boundary distance
    localparam int PW   = FW + gsct_pkg::DELTA_W;               // product
    localparam int EW   = FRACTION_BITS + 17;                   // error term
    localparam int CMPW = (CW > 6 ? CW : 6) + 1;                // grid compare
    localparam int IW   = gsct_pkg::INDEX_W;
    localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;

    // grid size registers
    logic [gsct_pkg::CFG_W-1:0] r_grid_columns, r_grid_rows;

    // segment and walk registers
    logic signed [CW-1:0]            r_ii, r_jj, r_kk, r_ll;
    logic [gsct_pkg::DELTA_W-1:0]    r_dx, r_dy;
    logic [FW-1:0]                   r_fx, r_fy;
    logic                            r_xdir, r_ydir;
    logic [gsct_pkg::TAG_W-1:0]      r_tag;
    logic signed [EW-1:0]            r_err;
    logic [NW-1:0]                   r_n;
    logic [gsct_pkg::COUNT_W-1:0]    r_count;

    // output word
    logic signed [gsct_pkg::CELL_W-1:0] r_out_x, r_out_y;
    logic [IW-1:0]                   r_out_index;
    logic [gsct_pkg::TAG_W-1:0]      r_out_tag;
    logic                            r_out_inside, r_out_last;

    // load-side decode
    logic                            w_xdir, w_ydir;
    logic [gsct_pkg::DELTA_W-1:0]    w_dx, w_dy;
    logic [FW-1:0]                   w_fx, w_fy;

    // setup
    logic [FW-1:0]                   w_mul_a;
    logic [gsct_pkg::DELTA_W-1:0]    w_mul_b;
    logic [PW-1:0]                   w_prod;
    logic signed [NW-1:0]            w_span_x, w_span_y;
    logic [NW-1:0]                   w_abs_x, w_abs_y;
    logic signed [CMPW-1:0]          w_ii_c, w_jj_c, w_kk_c, w_ll_c, w_cols_c, w_rows_c;
    logic                            w_outside, w_only_x, w_only_y, w_single;

    // walk
    logic                            w_fin, w_inside, w_go_y;
    logic [IW-1:0]                   w_index, w_cx8, w_cy8;

    always_comb begin
        w_xdir = i_x_end > i_x_start;
        w_ydir = i_y_end > i_y_start;
        w_dx   = w_xdir ? gsct_pkg::DELTA_W'(i_x_end - i_x_start)
                        : gsct_pkg::DELTA_W'(i_x_start - i_x_end);
        w_dy   = w_ydir ? gsct_pkg::DELTA_W'(i_y_end - i_y_start)
                        : gsct_pkg::DELTA_W'(i_y_start - i_y_end);
        // distance to the next boundary in the walk direction
        w_fx   = w_xdir ? ONE - {1'b0, i_x_start[FRACTION_BITS-1:0]}
                        : {1'b0, i_x_start[FRACTION_BITS-1:0]};
        w_fy   = w_ydir ? ONE - {1'b0, i_y_start[FRACTION_BITS-1:0]}
                        : {1'b0, i_y_start[FRACTION_BITS-1:0]};
    end

    // one multiplier, shared by the mul_x and mul_y setup steps
    assign w_mul_a = i_cmd.mul_x ? r_fx : r_fy;
    assign w_mul_b = i_cmd.mul_x ? r_dy : r_dx;
    assign w_prod  = PW'(w_mul_a) * PW'(w_mul_b);

    always_comb begin
        w_span_x = NW'(r_kk) - NW'(r_ii);
        w_span_y = NW'(r_ll) - NW'(r_jj);
        w_abs_x  = w_span_x[NW-1] ? NW'(-w_span_x) : NW'(w_span_x);
        w_abs_y  = w_span_y[NW-1] ? NW'(-w_span_y) : NW'(w_span_y);
        w_ii_c   = CMPW'(r_ii);
        w_jj_c   = CMPW'(r_jj);
        w_kk_c   = CMPW'(r_kk);
        w_ll_c   = CMPW'(r_ll);
        w_cols_c = CMPW'($signed({1'b0, r_grid_columns}));
        w_rows_c = CMPW'($signed({1'b0, r_grid_rows}));
        // cell box misses the grid entirely
        w_outside = (w_ii_c < 0 && w_kk_c < 0) ||
                    (w_ii_c >= w_cols_c && w_kk_c >= w_cols_c) ||
                    (w_jj_c < 0 && w_ll_c < 0) ||
                    (w_jj_c >= w_rows_c && w_ll_c >= w_rows_c);
        w_only_y = (r_dx == '0);
        w_only_x = (r_dy == '0);
        w_single = w_only_x || w_only_y;
    end

    always_comb begin
        w_fin    = (r_n == '0) ||
                   (r_count == gsct_pkg::COUNT_W'(gsct_pkg::MAX_RES - 1));
        w_inside = (w_ii_c >= 0) && (w_jj_c >= 0) &&
                   (w_ii_c < w_cols_c) && (w_jj_c < w_rows_c);
        w_cx8    = IW'(r_ii);
        w_cy8    = IW'(r_jj);
        w_index  = w_inside ? IW'(w_cx8 + w_cy8 * IW'(r_grid_columns)) : '0;
        // ties go to x
        w_go_y   = (w_only_y && !w_only_x) || (!w_only_x && r_err > 0);
    end

    assign o_sts.fin = w_fin;

    // grid registers: the user must write them only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= gsct_pkg::CFG_W'(MAX_GRID_SIDE);
            r_grid_rows    <= gsct_pkg::CFG_W'(MAX_GRID_SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gsct_pkg::CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                gsct_pkg::CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ii    <= '0;
            r_jj    <= '0;
            r_err   <= '0;
            r_n     <= '0;
            r_count <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
        end else if (i_cmd.load) begin
            r_ii    <= i_x_start[gsct_pkg::COORD_W-1:FRACTION_BITS];
            r_jj    <= i_y_start[gsct_pkg::COORD_W-1:FRACTION_BITS];
            r_dx    <= w_dx;
            r_dy    <= w_dy;
            r_count <= '0;
        end else if (i_cmd.mul_x) begin
            r_n   <= w_outside ? '0 : NW'(w_abs_x + w_abs_y);
            r_err <= w_single ? '0 : EW'(w_prod);
        end else if (i_cmd.mul_y) begin
            r_err <= w_single ? '0 : r_err - EW'(w_prod);
        end else if (i_cmd.step && !w_fin) begin
            if (w_go_y) begin
                r_jj  <= r_jj + (r_ydir ? CW'(1) : {CW{1'b1}});
                r_err <= r_err - (EW'(r_dx) << FRACTION_BITS);
            end else begin
                r_ii  <= r_ii + (r_xdir ? CW'(1) : {CW{1'b1}});
                r_err <= r_err + (EW'(r_dy) << FRACTION_BITS);
            end
            r_n     <= r_n - NW'(1);
            r_count <= r_count + gsct_pkg::COUNT_W'(1);
        end
    end

    // segment payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kk   <= i_x_end[gsct_pkg::COORD_W-1:FRACTION_BITS];
            r_ll   <= i_y_end[gsct_pkg::COORD_W-1:FRACTION_BITS];
            r_fx   <= w_fx;
            r_fy   <= w_fy;
            r_xdir <= w_xdir;
            r_ydir <= w_ydir;
            r_tag  <= i_segment_id;
        end
    end

    // output word, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_x      <= gsct_pkg::CELL_W'(r_ii);
            r_out_y      <= gsct_pkg::CELL_W'(r_jj);
            r_out_index  <= w_index;
            r_out_tag    <= r_tag;
            r_out_inside <= w_inside;
            r_out_last   <= w_fin;
        end
    end

    assign o_cell_x      = r_out_x;
    assign o_cell_y      = r_out_y;
    assign o_cell_index  = r_out_index;
    assign o_segment_tag = r_out_tag;
    assign o_inside_res  = r_out_inside;
    assign o_last        = r_out_last;

endmodule

FILE: hw/rtl/grid_segment_cell_traversal_core.sv
// ----------------------------------------------------------------------------
// grid_segment_cell_traversal_core: lists the grid cells crossed by a segment
// Integer error-term grid walk from the first endpoint to the second.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel (i_in_valid / o_in_stall): one word per segment, both
//    endpoints in cell units, signed fixed point, plus a segment id.
//  - Output channel (o_out_valid / i_out_stall): one word per visited cell,
//    o_last set on the final word of a segment. A segment whose cell box
//    misses the grid gives a single word with o_inside_res clear.
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//    grid_columns, index 1 grid_rows. Write only while the block is idle.
// Timing
//  - A segment passes through the accept state, the setup states ST_MUL_X and
//    ST_MUL_Y, in which one shared multiplier forms the x and y error products,
//    then the walk loop, one cell per cycle while the output register is free.
//  - The first word is written into the output register by the first walk step.
//  - The output register is refilled only when empty or being taken, so a
//    stall on the output freezes the walk; o_in_stall stays high until the
//    last word of the current segment has gone into the output register.
// Reset: synchronous, active low; grid registers return to the full grid,
//  the block comes up idle with no word pending.
// ----------------------------------------------------------------------------
module grid_segment_cell_traversal_core #(
    parameter int MAX_GRID_SIDE = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // segment input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_x_start,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_y_start,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_x_end,
    input  logic signed [gsct_pkg::COORD_W-1:0]    i_y_end,
    input  logic [gsct_pkg::TAG_W-1:0]             i_segment_id,
    // cell output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [gsct_pkg::CELL_W-1:0]     o_cell_x,
    output logic signed [gsct_pkg::CELL_W-1:0]     o_cell_y,
    output logic [gsct_pkg::INDEX_W-1:0]           o_cell_index,
    output logic [gsct_pkg::TAG_W-1:0]             o_segment_tag,
    output logic                                   o_inside_res,
    output logic                                   o_last,
    // configuration
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [gsct_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gsct_pkg::CFG_W-1:0]             i_cfg_data
);

    gsct_pkg::t_dp_cmd w_cmd;
    gsct_pkg::t_dp_sts w_sts;
    logic              w_cfg_we;

    // grid registers take a word every cycle
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    gsct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gsct_dpath #(
        .MAX_GRID_SIDE (MAX_GRID_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_segment_id  (i_segment_id),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_cell_index  (o_cell_index),
        .o_segment_tag (o_segment_tag),
        .o_inside_res  (o_inside_res),
        .o_last        (o_last)
    );

    // an accepted segment always holds the input off for its setup
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a segment was accepted");

    // the final cell releases the input channel
    a_last_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step && w_sts.fin) |=> !o_in_stall)
        else $error("input still stalled after the final cell");

    // never overwrite a word the receiver is holding off
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !(o_out_valid && i_out_stall))
        else $error("walk advanced over a stalled output word");

endmodule

FILE: tb/grid_segment_cell_traversal_checker.sv
// ----------------------------------------------------------------------------
// grid_segment_cell_traversal_checker: cell walk predictor and output compare
// Watches the segment, cell and config channels, works out the cells each
// accepted segment visits and compares every cell word taken from the block.
// ----------------------------------------------------------------------------
module grid_segment_cell_traversal_checker #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic signed [gsct_pkg::COORD_W-1:0]   i_x_start,
    input  logic signed [gsct_pkg::COORD_W-1:0]   i_y_start,
    input  logic signed [gsct_pkg::COORD_W-1:0]   i_x_end,
    input  logic signed [gsct_pkg::COORD_W-1:0]   i_y_end,
    input  logic [gsct_pkg::TAG_W-1:0]            i_segment_id,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [gsct_pkg::CELL_W-1:0]    i_cell_x,
    input  logic signed [gsct_pkg::CELL_W-1:0]    i_cell_y,
    input  logic [gsct_pkg::INDEX_W-1:0]          i_cell_index,
    input  logic [gsct_pkg::TAG_W-1:0]            i_segment_tag,
    input  logic                                  i_inside_res,
    input  logic                                  i_last,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [gsct_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gsct_pkg::CFG_W-1:0]            i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [gsct_pkg::CELL_W-1:0] cell_x;
        logic signed [gsct_pkg::CELL_W-1:0] cell_y;
        logic [gsct_pkg::INDEX_W-1:0]       lin_index;
        logic [gsct_pkg::TAG_W-1:0]         segment_tag;
        logic                               inside_res;
        logic                               last;
    } t_cell_visit;

    t_cell_visit                  expected_cells[$];
    logic [gsct_pkg::CFG_W-1:0]   grid_columns;
    logic [gsct_pkg::CFG_W-1:0]   grid_rows;

    function automatic t_cell_visit visit_of(input int cx, input int cy,
                                             input logic [gsct_pkg::TAG_W-1:0] tag,
                                             input bit last);
        t_cell_visit v;
        bit          in_grid;
        in_grid = cx >= 0 && cy >= 0 &&
                  cx < int'(grid_columns) && cy < int'(grid_rows);
        v.cell_x      = gsct_pkg::CELL_W'(cx);
        v.cell_y      = gsct_pkg::CELL_W'(cy);
        v.lin_index   = in_grid ? gsct_pkg::INDEX_W'(cx + cy * int'(grid_columns)) : '0;
        v.segment_tag = tag;
        v.inside_res  = in_grid;
        v.last        = last;
        return v;
    endfunction

    // append one expected word
    function automatic void queue_visit(input t_cell_visit v);
        expected_cells = {expected_cells, v};
    endfunction

    // error-term walk; one expected word per visited cell
    function automatic void walk_segment(input logic signed [gsct_pkg::COORD_W-1:0] xs,
                                         input logic signed [gsct_pkg::COORD_W-1:0] ys,
                                         input logic signed [gsct_pkg::COORD_W-1:0] xe,
                                         input logic signed [gsct_pkg::COORD_W-1:0] ye,
                                         input logic [gsct_pkg::TAG_W-1:0] tag);
        int     x1, y1, x2, y2;
        int     cx, cy, end_cx, end_cy;
        int     x_dir, y_dir, steps, count;
        longint err, adx, ady, one;
        bit     only_x, only_y, fin;
        x1 = int'(xs);
        y1 = int'(ys);
        x2 = int'(xe);
        y2 = int'(ye);
        one = longint'(1) << FRACTION_BITS;
        cx = x1 >>> FRACTION_BITS;
        cy = y1 >>> FRACTION_BITS;
        end_cx = x2 >>> FRACTION_BITS;
        end_cy = y2 >>> FRACTION_BITS;
        adx = (x2 > x1) ? x2 - x1 : x1 - x2;
        ady = (y2 > y1) ? y2 - y1 : y1 - y2;

        // cell bounding box misses the grid: a single word
        if ((cx > end_cx ? cx : end_cx) < 0 ||
            (cx < end_cx ? cx : end_cx) >= int'(grid_columns) ||
            (cy > end_cy ? cy : end_cy) < 0 ||
            (cy < end_cy ? cy : end_cy) >= int'(grid_rows)) begin
            queue_visit(visit_of(cx, cy, tag, 1'b1));
            return;
        end

        x_dir = 0;
        y_dir = 0;
        steps = 0;
        err = 0;
        only_x = 1'b0;
        only_y = 1'b0;
        if (adx == 0) begin
            only_y = 1'b1;
        end else if (x2 > x1) begin
            x_dir = 1;
            steps = end_cx - cx;
            err = (longint'(cx) * one + one - x1) * ady;
        end else begin
            x_dir = -1;
            steps = cx - end_cx;
            err = (x1 - longint'(cx) * one) * ady;
        end
        if (ady == 0) begin
            only_x = 1'b1;
            only_y = 1'b0;
        end else if (y2 > y1) begin
            y_dir = 1;
            steps += end_cy - cy;
            err -= (longint'(cy) * one + one - y1) * adx;
        end else begin
            y_dir = -1;
            steps += cy - end_cy;
            err -= (y1 - longint'(cy) * one) * adx;
        end
        if (only_x || only_y)
            err = 0;

        count = 0;
        do begin
            fin = (steps <= 0) || (count == gsct_pkg::MAX_RES - 1);
            queue_visit(visit_of(cx, cy, tag, fin));
            count++;
            if (!fin) begin
                // ties go to x
                if (only_y || (!only_x && err > 0)) begin
                    cy += y_dir;
                    err -= adx * one;
                end else begin
                    cx += x_dir;
                    err += ady * one;
                end
                steps--;
            end
        end while (!fin);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cell_visit want;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            grid_columns <= gsct_pkg::CFG_W'(16);
            grid_rows    <= gsct_pkg::CFG_W'(16);
            expected_cells.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    gsct_pkg::CFG_GRID_COLUMNS: grid_columns <= i_cfg_data;
                    gsct_pkg::CFG_GRID_ROWS:    grid_rows    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                walk_segment(i_x_start, i_y_start, i_x_end, i_y_end, i_segment_id);
            if (i_out_valid && !i_out_stall) begin
                if (expected_cells.size() == 0) begin
                    $error("unexpected cell word: cell_x %0d cell_y %0d tag %0h",
                           i_cell_x, i_cell_y, i_segment_tag);
                    errs++;
                end else begin
                    want = expected_cells.pop_front();
                    if (i_cell_x !== want.cell_x) begin
                        $error("o_cell_x: expected %0d, got %0d", want.cell_x, i_cell_x);
                        errs++;
                    end
                    if (i_cell_y !== want.cell_y) begin
                        $error("o_cell_y: expected %0d, got %0d", want.cell_y, i_cell_y);
                        errs++;
                    end
                    if (i_cell_index !== want.lin_index) begin
                        $error("o_cell_index: expected %0d, got %0d",
                               want.lin_index, i_cell_index);
                        errs++;
                    end
                    if (i_segment_tag !== want.segment_tag) begin
                        $error("o_segment_tag: expected %0h, got %0h",
                               want.segment_tag, i_segment_tag);
                        errs++;
                    end
                    if (i_inside_res !== want.inside_res) begin
                        $error("o_inside_res: expected %0b, got %0b",
                               want.inside_res, i_inside_res);
                        errs++;
                    end
                    if (i_last !== want.last) begin
                        $error("o_last: expected %0b, got %0b", want.last, i_last);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_cells.size();
    end

endmodule

FILE: tb/grid_segment_cell_traversal_core_tb.sv
// ----------------------------------------------------------------------------
// grid_segment_cell_traversal_core_tb: top of the cell walker testbench
// Drives segments and grid settings, stalls the cell channel in bursts and
// gives the verdict; prediction and comparison sit in the checker.
// ----------------------------------------------------------------------------
module grid_segment_cell_traversal_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRACTION_BITS = 8;
    localparam int CELL_ONE      = 1 << FRACTION_BITS;  // one cell, raw units
    localparam int HOLD_CYCLES   = 400;                  // long receiver hold-off
    localparam int DRAIN_CYCLES  = 8;                    // settle after the last word
    localparam int CYCLE_LIMIT   = 1000000;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic signed [gsct_pkg::COORD_W-1:0]  i_x_start;
    logic signed [gsct_pkg::COORD_W-1:0]  i_y_start;
    logic signed [gsct_pkg::COORD_W-1:0]  i_x_end;
    logic signed [gsct_pkg::COORD_W-1:0]  i_y_end;
    logic [gsct_pkg::TAG_W-1:0]           i_segment_id;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic signed [gsct_pkg::CELL_W-1:0]   o_cell_x;
    logic signed [gsct_pkg::CELL_W-1:0]   o_cell_y;
    logic [gsct_pkg::INDEX_W-1:0]         o_cell_index;
    logic [gsct_pkg::TAG_W-1:0]           o_segment_tag;
    logic                                 o_inside_res;
    logic                                 o_last;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [gsct_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [gsct_pkg::CFG_W-1:0]           i_cfg_data;

    int fail_count;
    int pending_cells;
    int cycle_count = 0;
    bit idle_on = 1'b1;     // random gaps on both channels
    bit hold_req = 1'b0;    // ask the stall process for one long hold-off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    grid_segment_cell_traversal_core #(
        .MAX_GRID_SIDE (16),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_segment_id  (i_segment_id),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_cell_index  (o_cell_index),
        .o_segment_tag (o_segment_tag),
        .o_inside_res  (o_inside_res),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    grid_segment_cell_traversal_checker #(
        .FRACTION_BITS (FRACTION_BITS)
    ) cell_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_segment_id  (i_segment_id),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_cell_x      (o_cell_x),
        .i_cell_y      (o_cell_y),
        .i_cell_index  (o_cell_index),
        .i_segment_tag (o_segment_tag),
        .i_inside_res  (o_inside_res),
        .i_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_cells)
    );

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // cell channel back-pressure: random bursts, or one long hold-off on
    // request so the block fills and stalls its segment input
    initial begin : out_stall_gen
        int burst;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 16);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // present one segment word and hold it until taken
    task automatic send_segment(input int xs, input int ys, input int xe,
                                input int ye, input int id);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_x_start    <= gsct_pkg::COORD_W'(xs);
        i_y_start    <= gsct_pkg::COORD_W'(ys);
        i_x_end      <= gsct_pkg::COORD_W'(xe);
        i_y_end      <= gsct_pkg::COORD_W'(ye);
        i_segment_id <= gsct_pkg::TAG_W'(id);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_grid_reg(input logic [gsct_pkg::CFG_IDX_W-1:0] idx,
                                  input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= gsct_pkg::CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // every segment yields at least one word, so an empty store means idle
    task automatic wait_drained();
        do @(posedge i_clk); while (pending_cells != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one grid setting, then a stream of random segments
    task automatic run_phase(input int cols, input int rows, input int n_items,
                             input bit idling, input bit hold);
        int k, kind, gap, span_x, span_y;
        int xs, ys, xe, ye;
        idle_on = idling;
        write_grid_reg(gsct_pkg::CFG_GRID_COLUMNS, cols);
        write_grid_reg(gsct_pkg::CFG_GRID_ROWS, rows);
        span_x = (cols > 0 ? cols : 1) * CELL_ONE;
        span_y = (rows > 0 ? rows : 1) * CELL_ONE;
        if (hold)
            hold_req = 1'b1;
        for (k = 0; k < n_items; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 67) begin
                // short segment around the grid, about one cell long
                xs = int'($urandom_range(0, span_x + 255)) - 128;
                ys = int'($urandom_range(0, span_y + 255)) - 128;
                xe = xs + int'($urandom_range(0, 3 * CELL_ONE)) - 384;
                ye = ys + int'($urandom_range(0, 3 * CELL_ONE)) - 384;
                // a share of them axis aligned, a few a single point
                if (kind >= 55) begin
                    if (kind == 66) begin
                        xe = xs;
                        ye = ys;
                    end else if (kind[0]) begin
                        xe = xs;
                    end else begin
                        ye = ys;
                    end
                end
            end else if (kind < 80) begin
                xs = int'($urandom_range(0, 8191)) - 2048;
                ys = int'($urandom_range(0, 8191)) - 2048;
                xe = int'($urandom_range(0, 8191)) - 2048;
                ye = int'($urandom_range(0, 8191)) - 2048;
            end else if (kind < 90) begin
                // whole box off one side of the grid
                xs = int'($urandom_range(0, 8191)) - 2048;
                ys = int'($urandom_range(0, 8191)) - 2048;
                xe = int'($urandom_range(0, 8191)) - 2048;
                ye = int'($urandom_range(0, 8191)) - 2048;
                case ($urandom_range(0, 3))
                    0: begin
                        xs = -1 - int'($urandom_range(0, 2047));
                        xe = -1 - int'($urandom_range(0, 2047));
                    end
                    1: begin
                        xs = span_x + int'($urandom_range(0, 1500));
                        xe = span_x + int'($urandom_range(0, 1500));
                    end
                    2: begin
                        ys = -1 - int'($urandom_range(0, 2047));
                        ye = -1 - int'($urandom_range(0, 2047));
                    end
                    default: begin
                        ys = span_y + int'($urandom_range(0, 1500));
                        ye = span_y + int'($urandom_range(0, 1500));
                    end
                endcase
            end else begin
                // anything the 14-bit fields can hold
                xs = int'($urandom_range(0, 16383));
                ys = int'($urandom_range(0, 16383));
                xe = int'($urandom_range(0, 16383));
                ye = int'($urandom_range(0, 16383));
            end
            send_segment(xs, ys, xe, ye, int'($urandom_range(0, 65535)));
            if (idling && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 16);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_x_start    = '0;
        i_y_start    = '0;
        i_x_end      = '0;
        i_y_end      = '0;
        i_segment_id = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = gsct_pkg::CFG_GRID_COLUMNS;
        i_cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the full 16 x 16 grid left by reset
        send_segment(0, 0, 0, 0, 0);                            // single point
        send_segment(128, 128, 128, 5 * CELL_ONE + 10, 16'hFFFF);  // zero dx
        send_segment(10 * CELL_ONE, 300, 2 * CELL_ONE + 5, 300, 1); // zero dy, -x
        send_segment(100, 100, 3 * CELL_ONE + 50, 2 * CELL_ONE + 200, 2);
        send_segment(9 * CELL_ONE + 20, 7 * CELL_ONE + 240, 6 * CELL_ONE + 3,
                     3 * CELL_ONE + 99, 3);                     // both directions down
        send_segment(128, 128, 384, 384, 4);                    // through a corner: tie
        send_segment(-2048, -2048, -300, -300, 5);              // box below/left
        send_segment(20 * CELL_ONE, 100, 6143, 9 * CELL_ONE, 6);   // box right of grid
        send_segment(100, 20 * CELL_ONE, 15 * CELL_ONE, 6143, 7);  // box above grid
        send_segment(-1000, 500, 1000, 700, 8);                 // walk leaves the grid
        send_segment(-2048, -2048, 6143, 6143, 9);              // longest in range
        send_segment(6143, -2048, -2048, 6143, 10);
        send_segment(-8192, -8192, 8191, 8191, 11);             // capped walk
        send_segment(8191, 0, -8192, 0, 12);                    // capped, zero dy
        send_segment(0, 8191, 0, -8192, 13);                    // capped, zero dx
        send_segment(0, 0, CELL_ONE, 0, 14);                    // end on a boundary
        send_segment(-1, -1, 1, 1, 15);                         // flooring below zero
        send_segment(15 * CELL_ONE + 100, 15 * CELL_ONE + 100,
                     17 * CELL_ONE, 16 * CELL_ONE + 30, 16);    // walks off the far corner
        send_segment(4 * CELL_ONE + 255, 4 * CELL_ONE, 4 * CELL_ONE, 4 * CELL_ONE + 255, 17);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        // random phases; the first carries the long hold-off, the last no gaps
        run_phase(16, 16, 30, 1'b1, 1'b1);
        run_phase(1, 1, 25, 1'b1, 1'b0);
        run_phase(16, 1, 25, 1'b1, 1'b0);
        run_phase(1, 16, 25, 1'b1, 1'b0);
        run_phase(31, 31, 20, 1'b1, 1'b0);      // beyond the grid limit
        run_phase(0, 7, 15, 1'b1, 1'b0);        // no columns: all outside
        run_phase(5, 0, 15, 1'b1, 1'b0);        // no rows: all outside
        run_phase(9, 13, 25, 1'b1, 1'b0);
        run_phase(16, 16, 20, 1'b0, 1'b0);

        if (pending_cells != 0)
            $error("%0d expected cell words never arrived", pending_cells);
        if (fail_count == 0 && pending_cells == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
